FILE: sv/per_core_utilization_percent_defines.svh
// Assertion helpers for the per-core utilization block.
`ifndef PER_CORE_UTILIZATION_PERCENT_DEFINES_SVH
`define PER_CORE_UTILIZATION_PERCENT_DEFINES_SVH

// Condition holds at every clock edge outside reset.
`define PCU_ASSERT_HOLDS(label, ck, rs, cond, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (cond)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define PCU_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/pcu_pkg.sv
package pcu_pkg;

  localparam int CORE_W     = 3;
  localparam int CORE_SLOTS = 2 ** CORE_W;
  localparam int MAX_CORES  = 8;
  localparam int TICK_W     = 48;
  localparam int USUM_W     = TICK_W + 1;
  localparam int SSUM_W     = TICK_W + 2;
  localparam int ISUM_W     = TICK_W + 1;
  localparam int PCT_W      = 7;
  localparam int PCT_MAX    = 100;

  // 100 * x = (x << 6) + (x << 5) + (x << 2)
  localparam int MUL_SH_A   = 6;
  localparam int MUL_SH_B   = 5;
  localparam int MUL_SH_C   = 2;

  // Quotient below 100 fits in PCT_W bits: one restoring step per bit.
  localparam int DIV_STEPS  = PCT_W;
  localparam int CNT_W      = $clog2(DIV_STEPS);

  // Deltas stay below 2^52 in magnitude, 100 * |busy| below 2^58.
  localparam int ACC_W      = 60;

endpackage

FILE: sv/pcu_if.sv
interface pcu_sample_if import pcu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CORE_W-1:0] core_index;
  logic [TICK_W-1:0] user_ticks;
  logic [TICK_W-1:0] nice_ticks;
  logic [TICK_W-1:0] system_ticks;
  logic [TICK_W-1:0] idle_ticks;
  logic [TICK_W-1:0] iowait_ticks;
  logic [TICK_W-1:0] irq_ticks;
  logic [TICK_W-1:0] softirq_ticks;
  logic [TICK_W-1:0] steal_ticks;

  modport source (
    output valid, core_index, user_ticks, nice_ticks, system_ticks, idle_ticks,
           iowait_ticks, irq_ticks, softirq_ticks, steal_ticks,
    input  ready
  );
  modport sink (
    input  valid, core_index, user_ticks, nice_ticks, system_ticks, idle_ticks,
           iowait_ticks, irq_ticks, softirq_ticks, steal_ticks,
    output ready
  );
endinterface

interface pcu_result_if import pcu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PCT_W-1:0] busy_percent;

  modport source (output valid, busy_percent, input ready);
  modport sink (input valid, busy_percent, output ready);
endinterface

FILE: sv/per_core_utilization_percent.sv
// Flow: an item resolves early (unknown core, zero total, opposite signs, or
//   saturation at 100), else goes on through the multiply and divide states.
// Throughput: one item at a time; next item taken the cycle after the result
//   is taken. All arithmetic goes through one shared 60-bit add/subtract unit
//   stepped by the sequencer.
// Reset: rst (sync, active high) returns to idle and clears the stored sums.
`include "per_core_utilization_percent_defines.svh"

module per_core_utilization_percent import pcu_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  pcu_sample_if.sink   sample,
  pcu_result_if.source result
);

  // Sequencer states, one-hot.
  typedef enum logic [17:0] {
    ST_IDLE = 18'b000000000000000001,
    ST_SU   = 18'b000000000000000010,  // user + nice
    ST_SS1  = 18'b000000000000000100,  // system + irq
    ST_SS2  = 18'b000000000000001000,  // + softirq
    ST_SS3  = 18'b000000000000010000,  // + steal
    ST_SI   = 18'b000000000000100000,  // idle + iowait
    ST_B1   = 18'b000000000001000000,  // busy = usum - last user
    ST_B2   = 18'b000000000010000000,  // busy += ssum
    ST_B3   = 18'b000000000100000000,  // busy -= last system
    ST_T1   = 18'b000000001000000000,  // total = busy + isum
    ST_T2   = 18'b000000010000000000,  // total -= last idle, store new sums
    ST_NB   = 18'b000000100000000000,  // |busy|
    ST_NT   = 18'b000001000000000000,  // |total|
    ST_CMP  = 18'b000010000000000000,  // |busy| vs |total|, early outs
    ST_M1   = 18'b000100000000000000,  // rem = 96 * |busy|
    ST_M2   = 18'b001000000000000000,  // rem += 4 * |busy|
    ST_DIV  = 18'b010000000000000000,  // restoring divide, one bit a cycle
    ST_OUT  = 18'b100000000000000000   // result held until taken
  } state_t;

  state_t state;

  // Latched item.
  logic [CORE_W-1:0] core_q;
  logic [TICK_W-1:0] user_q, nice_q, system_q, idle_q;
  logic [TICK_W-1:0] iowait_q, irq_q, softirq_q, steal_q;

  // Working registers.
  logic [USUM_W-1:0] usum;
  logic [SSUM_W-1:0] ssum;
  logic [ISUM_W-1:0] isum;
  logic [ACC_W-1:0]  busy;   // two's complement, later magnitude
  logic [ACC_W-1:0]  total;  // two's complement, later magnitude, then divisor
  logic [ACC_W-1:0]  rem;
  logic              neg_b;
  logic              neg_t;
  logic              zero_t;
  logic [CNT_W-1:0]  cnt;
  logic [PCT_W-1:0]  pct;

  // Per-core stored sums; reset value is zero.
  logic [USUM_W-1:0] last_user   [CORE_SLOTS];
  logic [SSUM_W-1:0] last_system [CORE_SLOTS];
  logic [ISUM_W-1:0] last_idle   [CORE_SLOTS];

  // Shared add/subtract unit.
  logic [ACC_W-1:0] opa;
  logic [ACC_W-1:0] opb;
  logic             sub;
  logic [ACC_W-1:0] sum;
  logic             sum_neg;
  logic             core_ok;
  logic             accept;
  logic             pct_in_range;

  assign accept  = sample.valid && sample.ready;
  assign core_ok = 32'(sample.core_index) < MAX_CORES;
  assign sum     = opa + (sub ? ~opb : opb) + ACC_W'(sub);
  assign sum_neg = sum[ACC_W-1];

  always_comb begin
    opa = '0;
    opb = '0;
    sub = 1'b0;
    unique case (state)
      ST_SU: begin
        opa = ACC_W'(user_q);
        opb = ACC_W'(nice_q);
      end
      ST_SS1: begin
        opa = ACC_W'(system_q);
        opb = ACC_W'(irq_q);
      end
      ST_SS2: begin
        opa = ACC_W'(ssum);
        opb = ACC_W'(softirq_q);
      end
      ST_SS3: begin
        opa = ACC_W'(ssum);
        opb = ACC_W'(steal_q);
      end
      ST_SI: begin
        opa = ACC_W'(idle_q);
        opb = ACC_W'(iowait_q);
      end
      ST_B1: begin
        opa = ACC_W'(usum);
        opb = ACC_W'(last_user[core_q]);
        sub = 1'b1;
      end
      ST_B2: begin
        opa = busy;
        opb = ACC_W'(ssum);
      end
      ST_B3: begin
        opa = busy;
        opb = ACC_W'(last_system[core_q]);
        sub = 1'b1;
      end
      ST_T1: begin
        opa = busy;
        opb = ACC_W'(isum);
      end
      ST_T2: begin
        opa = total;
        opb = ACC_W'(last_idle[core_q]);
        sub = 1'b1;
      end
      ST_NB: begin
        opb = busy;
        sub = 1'b1;
      end
      ST_NT: begin
        opb = total;
        sub = 1'b1;
      end
      ST_CMP: begin
        opa = busy;
        opb = total;
        sub = 1'b1;
      end
      ST_M1: begin
        opa = busy << MUL_SH_A;
        opb = busy << MUL_SH_B;
      end
      ST_M2: begin
        opa = rem;
        opb = busy << MUL_SH_C;
      end
      ST_DIV: begin
        opa = rem;
        opb = total;
        sub = 1'b1;
      end
      default: begin
        opa = '0;
      end
    endcase
  end

  // Sequencer and datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            core_q    <= sample.core_index;
            user_q    <= sample.user_ticks;
            nice_q    <= sample.nice_ticks;
            system_q  <= sample.system_ticks;
            idle_q    <= sample.idle_ticks;
            iowait_q  <= sample.iowait_ticks;
            irq_q     <= sample.irq_ticks;
            softirq_q <= sample.softirq_ticks;
            steal_q   <= sample.steal_ticks;
            if (core_ok) begin
              state <= ST_SU;
            end else begin
              // unknown core: no state change, result 0
              pct   <= '0;
              state <= ST_OUT;
            end
          end
        end
        ST_SU: begin
          usum  <= sum[USUM_W-1:0];
          state <= ST_SS1;
        end
        ST_SS1: begin
          ssum  <= sum[SSUM_W-1:0];
          state <= ST_SS2;
        end
        ST_SS2: begin
          ssum  <= sum[SSUM_W-1:0];
          state <= ST_SS3;
        end
        ST_SS3: begin
          ssum  <= sum[SSUM_W-1:0];
          state <= ST_SI;
        end
        ST_SI: begin
          isum  <= sum[ISUM_W-1:0];
          state <= ST_B1;
        end
        ST_B1: begin
          busy  <= sum;
          state <= ST_B2;
        end
        ST_B2: begin
          busy  <= sum;
          state <= ST_B3;
        end
        ST_B3: begin
          busy  <= sum;
          state <= ST_T1;
        end
        ST_T1: begin
          total <= sum;
          state <= ST_T2;
        end
        ST_T2: begin
          total <= sum;
          state <= ST_NB;
        end
        ST_NB: begin
          neg_b <= busy[ACC_W-1];
          if (busy[ACC_W-1]) begin
            busy <= sum;
          end
          state <= ST_NT;
        end
        ST_NT: begin
          neg_t  <= total[ACC_W-1];
          zero_t <= (total == '0);
          if (total[ACC_W-1]) begin
            total <= sum;
          end
          state <= ST_CMP;
        end
        ST_CMP: begin
          // zero total, or opposite signs (a quotient of zero or below), clamp to 0;
          // |busy| >= |total| means a quotient of 100 or more
          if (zero_t || (neg_b != neg_t)) begin
            pct   <= '0;
            state <= ST_OUT;
          end else if (!sum_neg) begin
            pct   <= PCT_W'(PCT_MAX);
            state <= ST_OUT;
          end else begin
            state <= ST_M1;
          end
        end
        ST_M1: begin
          rem   <= sum;
          state <= ST_M2;
        end
        ST_M2: begin
          rem   <= sum;
          total <= total << (DIV_STEPS - 1);
          cnt   <= CNT_W'(DIV_STEPS - 1);
          pct   <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (!sum_neg) begin
            rem <= sum;
          end
          pct   <= {pct[PCT_W-2:0], !sum_neg};
          total <= total >> 1;
          cnt   <= cnt - CNT_W'(1);
          if (cnt == '0) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (result.ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Stored sums: new sums replace old ones once all three deltas are read.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CORE_SLOTS; i++) begin
        last_user[i]   <= '0;
        last_system[i] <= '0;
        last_idle[i]   <= '0;
      end
    end else if (state == ST_T2) begin
      last_user[core_q]   <= usum;
      last_system[core_q] <= ssum;
      last_idle[core_q]   <= isum;
    end
  end

  assign sample.ready        = (state == ST_IDLE);
  assign result.valid        = (state == ST_OUT);
  assign result.busy_percent = pct;
  assign pct_in_range        = (pct <= PCT_W'(PCT_MAX));

  // One item in flight: never ready while a result waits.
  `PCU_ASSERT_HOLDS(a_one_item, clk, rst, !(sample.ready && result.valid), "ready while busy")
  // Result never exceeds the saturation bound.
  `PCU_ASSERT_HOLDS(a_pct_range, clk, rst, !result.valid || pct_in_range, "busy_percent above 100")
  // An accepted item makes the block busy in the next cycle.
  `PCU_ASSERT_NEXT(a_busy_after_accept, clk, rst, accept, !sample.ready, "ready after accept")

endmodule
